FILE: rtl/ranked_rect_point_query_core_assert.svh
// Assertion macros shared by the block's RTL.
`ifndef RANKED_RECT_POINT_QUERY_CORE_ASSERT_SVH
`define RANKED_RECT_POINT_QUERY_CORE_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define RRPQ_ASSERT_IMP(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
	else $error("rrpq assertion failed");

// Next-cycle implication checked outside reset.
`define RRPQ_ASSERT_NXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
	else $error("rrpq assertion failed");

`endif

FILE: rtl/rrpq_pkg.sv
// ---------------------------------------------------------------------------
// rrpq_pkg
// Types, constants and codes shared by the ranked rectangle point query core.
// ---------------------------------------------------------------------------
package rrpq_pkg;

	localparam int CAPACITY    = 1024;
	localparam int MAX_RESULTS = 64;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int K_W         = 7;

	localparam logic [1:0] REQ_CLEAR = 2'd0;
	localparam logic [1:0] REQ_LOAD  = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	localparam logic [2:0] ST_FOUND   = 3'd0;
	localparam logic [2:0] ST_NOMATCH = 3'd1;
	localparam logic [2:0] ST_LOADED  = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_CLEARED = 3'd4;

	localparam logic [1:0] OP_HOLD   = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_ROTATE = 2'd2;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] rank;
		logic signed [7:0]  id;
	} point_t;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_rank;
		logic signed [7:0]  point_id;
		logic signed [31:0] rect_low_x;
		logic signed [31:0] rect_low_y;
		logic signed [31:0] rect_high_x;
		logic signed [31:0] rect_high_y;
		logic [K_W-1:0]     max_count;
	} req_t;

	typedef struct packed {
		logic [2:0]         status;
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_rank;
		logic signed [7:0]  out_id;
		logic               is_last;
	} rsp_t;

	typedef struct packed {
		logic [1:0]       op;
		logic [CNT_W-1:0] count;
		point_t           pt;
	} cell_ctl_t;

endpackage

FILE: rtl/rrpq_cell.sv
// ---------------------------------------------------------------------------
// rrpq_cell
// One slot of the rank-ordered point chain: sorted insert or ring rotation.
// ---------------------------------------------------------------------------
module rrpq_cell import rrpq_pkg::*; (
	input  logic             clk,
	input  logic [IDX_W-1:0] index,
	input  cell_ctl_t        ctl,
	input  point_t           prev_pt,
	input  logic             prev_shift,
	input  point_t           next_pt,
	output point_t           pt,
	output logic             shift
);

	point_t pt_q;
	logic   occupied;
	logic   at_tail;

	assign pt       = pt_q;
	assign occupied = {1'b0, index} < ctl.count;
	assign at_tail  = {1'b0, index} == ctl.count;
	// An occupied slot with a strictly larger rank moves one place down.
	assign shift    = occupied && (pt_q.rank > ctl.pt.rank);

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_INSERT: begin
				if (prev_shift)
					pt_q <= prev_pt;
				else if (shift || at_tail)
					pt_q <= ctl.pt;
			end
			OP_ROTATE: pt_q <= next_pt;
			default: ;
		endcase
	end

endmodule

FILE: rtl/ranked_rect_point_query_core.sv
// ---------------------------------------------------------------------------
// ranked_rect_point_query_core
// Point table kept in rank order in a chain of cells, with rectangle queries.
// ---------------------------------------------------------------------------
//
//  Channel    Ports                 Handshake
//  request    start, busy, req      transaction when start && !busy
//  response   rsp_strobe, rsp       one-cycle strobe per result, cannot be stalled
//
// A clear or a load is answered from a register: its result appears on the next
// cycle and busy stays low, so these may follow each other in every cycle.
// A query rotates the whole ring of CAPACITY cells once (one cell per cycle),
// then gives the final result from the flush state, with busy high throughout;
// a query with a zero limit goes straight to the flush state. The ring length sets how long busy stays high.
// Reset clears the point count and control; the cell contents need none.
// Results are never held back: the receiver takes each one in its cycle.
`include "ranked_rect_point_query_core_assert.svh"

module ranked_rect_point_query_core import rrpq_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	output logic   busy,
	input  req_t   req,
	output logic   rsp_strobe,
	output rsp_t   rsp
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_FLUSH = 2'd2;

	logic [1:0]       state_q;
	logic [IDX_W-1:0] step_q;
	logic [CNT_W-1:0] count_q;
	logic [K_W-1:0]   k_q;
	logic [K_W-1:0]   found_q;
	logic signed [31:0] lx_q, ly_q, hx_q, hy_q;
	point_t           pend_q;
	logic             pend_v_q;
	logic             strobe_q;
	rsp_t             rsp_q;

	cell_ctl_t        ctl;
	point_t           cell_pt [CAPACITY];
	logic             cell_shift [CAPACITY];
	point_t           head;
	logic             accept;
	logic             hit;
	logic [K_W-1:0]   k_sat;
	rsp_t             idle_rsp;

	assign accept     = start && !busy;
	assign busy       = state_q != S_IDLE;
	assign rsp_strobe = strobe_q;
	assign rsp        = rsp_q;
	assign head       = cell_pt[0];
	assign k_sat      = (req.max_count > K_W'(MAX_RESULTS)) ? K_W'(MAX_RESULTS)
	                                                       : req.max_count;

	// Loads reach the chain straight from the request; queries rotate it.
	always_comb begin
		ctl.count   = count_q;
		ctl.pt.x    = req.point_x;
		ctl.pt.y    = req.point_y;
		ctl.pt.rank = req.point_rank;
		ctl.pt.id   = req.point_id;
		ctl.op      = OP_HOLD;
		if (state_q == S_SCAN)
			ctl.op = OP_ROTATE;
		else if (accept && req.req_type == REQ_LOAD && count_q != CNT_W'(CAPACITY))
			ctl.op = OP_INSERT;
	end

	// Single-result answer for a clear or a load taken while idle.
	always_comb begin
		idle_rsp         = '0;
		idle_rsp.is_last = 1'b1;
		if (req.req_type == REQ_CLEAR)
			idle_rsp.status = ST_CLEARED;
		else if (count_q == CNT_W'(CAPACITY))
			idle_rsp.status = ST_FULL;
		else
			idle_rsp.status = ST_LOADED;
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		rrpq_cell u_cell (
			.clk        (clk),
			.index      (IDX_W'(i)),
			.ctl        (ctl),
			.prev_pt    ((i == 0) ? ctl.pt : cell_pt[(i + CAPACITY - 1) % CAPACITY]),
			.prev_shift ((i == 0) ? 1'b0 : cell_shift[(i + CAPACITY - 1) % CAPACITY]),
			.next_pt    (cell_pt[(i + 1) % CAPACITY]),
			.pt         (cell_pt[i]),
			.shift      (cell_shift[i])
		);
	end

	// The head cell holds the entry of rank position step_q during a scan.
	assign hit = ({1'b0, step_q} < count_q) && (found_q != k_q)
		&& (head.x >= lx_q) && (head.x <= hx_q)
		&& (head.y >= ly_q) && (head.y <= hy_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			count_q  <= '0;
			k_q      <= '0;
			found_q  <= '0;
			pend_v_q <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_CLEAR: begin
								count_q  <= '0;
								strobe_q <= 1'b1;
							end
							REQ_LOAD: begin
								if (count_q != CNT_W'(CAPACITY))
									count_q <= count_q + 1'b1;
								strobe_q <= 1'b1;
							end
							REQ_QUERY: begin
								k_q      <= k_sat;
								found_q  <= '0;
								pend_v_q <= 1'b0;
								step_q   <= '0;
								state_q  <= (k_sat == '0) ? S_FLUSH : S_SCAN;
							end
							default: ;
						endcase
					end
				end
				S_SCAN: begin
					if (hit) begin
						pend_v_q <= 1'b1;
						found_q  <= found_q + 1'b1;
						strobe_q <= pend_v_q;
					end
					step_q <= step_q + 1'b1;
					if (step_q == IDX_W'(CAPACITY - 1))
						state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload and the held-back match, which waits to learn if it is last.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					lx_q <= req.rect_low_x;
					ly_q <= req.rect_low_y;
					hx_q <= req.rect_high_x;
					hy_q <= req.rect_high_y;
				end
				rsp_q <= idle_rsp;
			end
			S_SCAN: begin
				if (hit) begin
					pend_q         <= head;
					rsp_q.status   <= ST_FOUND;
					rsp_q.out_x    <= pend_q.x;
					rsp_q.out_y    <= pend_q.y;
					rsp_q.out_rank <= pend_q.rank;
					rsp_q.out_id   <= pend_q.id;
					rsp_q.is_last  <= 1'b0;
				end
			end
			S_FLUSH: begin
				rsp_q.is_last <= 1'b1;
				if (pend_v_q) begin
					rsp_q.status   <= ST_FOUND;
					rsp_q.out_x    <= pend_q.x;
					rsp_q.out_y    <= pend_q.y;
					rsp_q.out_rank <= pend_q.rank;
					rsp_q.out_id   <= pend_q.id;
				end else begin
					rsp_q.status   <= ST_NOMATCH;
					rsp_q.out_x    <= '0;
					rsp_q.out_y    <= '0;
					rsp_q.out_rank <= '0;
					rsp_q.out_id   <= '0;
				end
			end
			default: ;
		endcase
	end

	// The table never holds more points than it has cells.
	`RRPQ_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CNT_W'(CAPACITY))
	// A query never returns more points than its limit.
	`RRPQ_ASSERT_IMP(a_found_bound, state_q == S_SCAN, found_q <= k_q)
	// Every result that is not a found point closes its transaction.
	`RRPQ_ASSERT_IMP(a_single_last, rsp_strobe && rsp.status != ST_FOUND, rsp.is_last)
	// An accepted query with a nonzero limit starts a scan.
	`RRPQ_ASSERT_NXT(a_query_scan, accept && req.req_type == REQ_QUERY && k_sat != '0, state_q == S_SCAN)

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ranked_rect_point_query_core. A driver sends clear,
// load and rectangle query transactions from a queue with random gaps. A
// predictor keeps its own rank-ordered point table and computes the results
// of every transaction. A monitor compares each result strobe with the oldest
// prediction.
// ----------------------------------------------------------------------------
module testbench;
	import rrpq_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// A query can be busy for a full ring pass and then wait out a sender gap.
	localparam int QUIET_LIMIT = 4 * (CAPACITY + 20);
	localparam int TAIL_CYCLES = CAPACITY + 20;

	// Request code with no function; the block must ignore it.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	typedef struct {
		req_t r;
		int   gap;
		bit   drain;
	} pending_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic rsp_strobe;
	rsp_t rsp;

	pending_t pending_q[$];
	rsp_t     expected_q[$];
	int       errors = 0;
	int       waited;
	int       quiet;

	// Own copy of the point table: storage in load order plus an index list
	// in ascending rank order.
	point_t   table_pts [CAPACITY];
	int       rank_list [CAPACITY];
	int       n_points = 0;

	ranked_rect_point_query_core i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.rsp_strobe (rsp_strobe),
		.rsp        (rsp)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic rsp_t short_answer(logic [2:0] st);
		rsp_t a;
		a = '0;
		a.status = st;
		a.is_last = 1'b1;
		return a;
	endfunction

	// Works out the results of one accepted transaction and updates the table.
	function automatic void predict_results(req_t t);
		int   pos;
		int   k;
		int   found;
		rsp_t a;
		point_t p;
		case (t.req_type)
			REQ_CLEAR: begin
				n_points = 0;
				expected_q.push_back(short_answer(ST_CLEARED));
			end
			REQ_LOAD: begin
				if (n_points >= CAPACITY) begin
					expected_q.push_back(short_answer(ST_FULL));
				end else begin
					table_pts[n_points] = '{t.point_x, t.point_y, t.point_rank, t.point_id};
					// Equal ranks stay in load order: insert before the first
					// strictly greater rank.
					pos = n_points;
					for (int i = 0; i < n_points; i++) begin
						if (table_pts[rank_list[i]].rank > t.point_rank) begin
							pos = i;
							break;
						end
					end
					for (int i = n_points; i > pos; i--)
						rank_list[i] = rank_list[i-1];
					rank_list[pos] = n_points;
					n_points++;
					expected_q.push_back(short_answer(ST_LOADED));
				end
			end
			REQ_QUERY: begin
				k = (t.max_count > MAX_RESULTS) ? MAX_RESULTS : int'(t.max_count);
				found = 0;
				for (int i = 0; i < n_points && found < k; i++) begin
					p = table_pts[rank_list[i]];
					if (p.x >= t.rect_low_x && p.x <= t.rect_high_x &&
					    p.y >= t.rect_low_y && p.y <= t.rect_high_y) begin
						a = '{ST_FOUND, p.x, p.y, p.rank, p.id, 1'b0};
						expected_q.push_back(a);
						found++;
					end
				end
				if (found == 0)
					expected_q.push_back(short_answer(ST_NOMATCH));
				else
					expected_q[$].is_last = 1'b1;
			end
			default: begin
			end
		endcase
	endfunction

	// Driver: start stays up until the block takes the transaction. A new
	// item may follow in the very next cycle when its gap is zero.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start  <= 1'b0;
			req    <= '0;
			waited <= 0;
		end else begin
			if (start && !busy)
				predict_results(req);
			if (start && busy) begin
			end else if (pending_q.size() > 0 && waited >= pending_q[0].gap &&
			             (!pending_q[0].drain || expected_q.size() == 0)) begin
				start  <= 1'b1;
				req    <= pending_q[0].r;
				waited <= 0;
				void'(pending_q.pop_front());
			end else begin
				start  <= 1'b0;
				waited <= waited + 1;
			end
		end
	end

	// Monitor: every strobe is one result and must match the oldest prediction.
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && rsp_strobe) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $time, rsp);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (rsp.status !== e.status || rsp.out_x !== e.out_x ||
				    rsp.out_y !== e.out_y || rsp.out_rank !== e.out_rank ||
				    rsp.out_id !== e.out_id || rsp.is_last !== e.is_last) begin
					$display("%0t: result mismatch, expected %p, actual %p",
					         $time, e, rsp);
					errors++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which no transaction and no result moves.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || rsp_strobe)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("** ranked_rect_point_query_core: FAILED **");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_coord();
		case ($urandom_range(3, 0))
			0: return $urandom();
			1: return $urandom_range(2, 0) == 0 ? 32'sh8000_0000 : 32'sh7fff_ffff;
			default: return $signed($urandom_range(40, 0)) - 20;
		endcase
	endfunction

	task automatic add_item(req_t r, bit drain = 1'b0, int gap = -1);
		pending_t p;
		p.r     = r;
		p.drain = drain;
		p.gap   = (gap >= 0) ? gap : $urandom_range(18, 0);
		pending_q.push_back(p);
	endtask

	task automatic add_load(logic signed [31:0] x, logic signed [31:0] y,
	                        logic signed [31:0] rk, logic signed [7:0] id, int gap = -1);
		req_t r;
		r = req_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
		            $urandom(), $urandom(), $urandom(), $urandom()});
		r.req_type   = REQ_LOAD;
		r.point_x    = x;
		r.point_y    = y;
		r.point_rank = rk;
		r.point_id   = id;
		add_item(r, 1'b0, gap);
	endtask

	task automatic add_query(logic signed [31:0] lx, logic signed [31:0] ly,
	                         logic signed [31:0] hx, logic signed [31:0] hy,
	                         logic [K_W-1:0] k, bit drain = 1'b0);
		req_t r;
		r = req_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
		            $urandom(), $urandom(), $urandom(), $urandom()});
		r.req_type    = REQ_QUERY;
		r.rect_low_x  = lx;
		r.rect_low_y  = ly;
		r.rect_high_x = hx;
		r.rect_high_y = hy;
		r.max_count   = k;
		add_item(r, drain);
	endtask

	task automatic add_simple(logic [1:0] kind);
		req_t r;
		r = req_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
		            $urandom(), $urandom(), $urandom(), $urandom()});
		r.req_type = kind;
		add_item(r);
	endtask

	initial begin
		localparam logic signed [31:0] LO = 32'sh8000_0000;
		localparam logic signed [31:0] HI = 32'sh7fff_ffff;
		int burst;
		int kind;
		logic signed [31:0] ax;
		logic signed [31:0] ay;

		arst_n   = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: empty table, extreme points, rank ties, limits of k,
		// empty rectangle and the unused request code.
		add_simple(REQ_CLEAR);
		add_query(LO, LO, HI, HI, 7'd5);
		add_load(LO, LO, HI, 8'sh80);
		add_load(HI, HI, LO, 8'sh7f);
		add_load(0, 0, 32'sd7, 8'sd1);
		add_load(0, 0, 32'sd7, 8'sd2);
		add_load(-32'sd1, 32'sd1, 32'sd7, -8'sd1);
		add_query(LO, LO, HI, HI, 7'd127);
		add_query(LO, LO, HI, HI, 7'd0);
		add_query(-32'sd1, -32'sd1, 32'sd0, 32'sd1, 7'd2);
		add_query(32'sd5, LO, 32'sd4, HI, 7'd64);
		add_simple(REQ_UNUSED);
		add_query(HI, HI, HI, HI, 7'd1);
		add_query(LO, LO, HI, HI, 7'd100, 1'b1);
		add_query(-32'sd5, -32'sd5, 32'sd5, 32'sd5, 7'd3);
		add_simple(REQ_CLEAR);

		// Random part: mostly loads and queries over a small coordinate range
		// so rectangles hit, with occasional clears and unused codes.
		burst = 0;
		for (int i = 0; i < 185; i++) begin
			kind = $urandom_range(99, 0);
			if (kind < 3) begin
				add_simple(REQ_CLEAR);
			end else if (kind < 7) begin
				add_simple(REQ_UNUSED);
			end else if (kind < 62) begin
				add_load(pick_coord(), pick_coord(),
				         ($urandom_range(4, 0) == 0) ? $urandom() : $urandom_range(30, 0),
				         8'($urandom()), (burst % 30 < 10) ? 0 : -1);
			end else begin
				ax = pick_coord();
				ay = pick_coord();
				add_query(ax, ay, ax + $signed($urandom_range(25, 0)),
				          ay + $signed($urandom_range(25, 0)),
				          K_W'(($urandom_range(3, 0) == 0) ? $urandom_range(127, 0)
				                                           : $urandom_range(6, 0)),
				          $urandom_range(15, 0) == 0);
			end
			burst++;
		end

		do
			@(posedge clk);
		while (pending_q.size() > 0 || start || expected_q.size() > 0);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("** ranked_rect_point_query_core: PASSED **");
		else
			$display("** ranked_rect_point_query_core: FAILED **");
		$finish;
	end

endmodule
